// ===== hw/rtl/lfp_pkg.sv =====
// Package for the LED frame packer: word types, register indexes, frame constants,
// pixel packing and the CRC-32 byte update.
// No dependencies.
`default_nettype none

package lfp_pkg;

   localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
   localparam logic [7:0]  BYTE_ESC    = 8'hF5;
   localparam logic [7:0]  BYTE_ESC_SUB = 8'hF4;
   localparam logic [7:0]  BYTE_SYNC0  = 8'hAB;
   localparam logic [7:0]  BYTE_SYNC1  = 8'hCD;
   localparam logic [7:0]  CMD_SMOOTH  = 8'h11;
   localparam logic [7:0]  CMD_PLAIN   = 8'h10;
   localparam logic [7:0]  SMOOTH_MAX  = 8'd49;
   localparam logic [7:0]  FW_CRC_MIN  = 8'd4;   // trailer sent above this version
   localparam logic [7:0]  ESC_FLIP_B1 = 8'h20;
   localparam logic [7:0]  ESC_FLIP_B2 = 8'h08;
   localparam logic [7:0]  MASK_888    = 8'hF0;
   localparam logic [7:0]  MASK_555    = 8'hFF;

   // Configuration register indexes
   localparam logic [1:0] CSR_COLOR_MODE = 2'd0;
   localparam logic [1:0] CSR_SMOOTHING  = 2'd1;
   localparam logic [1:0] CSR_USE_CRC    = 2'd2;
   localparam logic [1:0] CSR_FW_VERSION = 2'd3;

   typedef struct packed {
      logic       color_mode;
      logic [7:0] smoothing_level;
      logic       use_crc;
      logic [7:0] firmware_version;
   } cfg_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } pixel_type;

   typedef struct packed {
      logic [7:0] b2;
      logic [7:0] b1;
      logic [7:0] b0;
      logic [1:0] last_idx;   // 2 for GRB888, 1 for RGB555
   } packed_pix_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_PIX,
      ST_PAD,
      ST_TRAIL,
      ST_CLOSE
   } emit_state_type;

   function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {data, 24'h00_0000};
      for (int i = 0; i < 8; i++) begin
         c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
      end
      return c;
   endfunction

   function automatic logic [7:0] esc_sub(input logic [7:0] b);
      return (b == BYTE_ESC) ? BYTE_ESC_SUB : b;
   endfunction

   function automatic packed_pix_type pack_pixel(input logic mode, input pixel_type p);
      packed_pix_type r;
      logic [4:0] r5;
      logic [4:0] g5;
      logic [4:0] b5;
      logic [7:0] x1;
      logic [7:0] x2;
      r5 = p.red[7:3];
      g5 = p.green[7:3];
      b5 = p.blue[7:3];
      x1 = {g5[1:0], 1'b0, r5};
      x2 = {b5, g5[4:2]};
      if (!mode) begin
         r.b0       = esc_sub(p.green);
         r.b1       = esc_sub(p.red);
         r.b2       = esc_sub(p.blue);
         r.last_idx = 2'd2;
      end else begin
         r.b0       = (x1 == BYTE_ESC) ? (x1 ^ ESC_FLIP_B1) : x1;
         r.b1       = (x2 == BYTE_ESC) ? (x2 ^ ESC_FLIP_B2) : x2;
         r.b2       = 8'h00;
         r.last_idx = 2'd1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/led_frame_packer_crc.sv =====
// Top level of the LED frame packer with CRC-32 trailer: input word buffer,
// configuration registers and byte sequencer.
// Uses lfp_pkg, lfp_cfg_regs and lfp_emitter.
//
// Usage
//   req_*  : one RGB pixel per word, tlast marks the last pixel of a frame.
//   rsp_*  : one frame byte per word, tlast on the closing F5 byte.
//   csr_*  : register write port, write only while the block is idle.
//   A frame opens with AB CD, a command byte and a config byte (four words),
//   then two (RGB555) or three (GRB888) bytes per pixel. After the last
//   pixel, when the trailer goes out with the CRC on, the CRC is padded
//   over zero bytes to a four-byte multiple (up to three pad bytes, no
//   output), a four-byte trailer follows for firmware above 4, and F5
//   closes the frame. An item passes the input buffer, the item register
//   and the output word register. The output register moves one byte per
//   cycle while the receiver does not stall; the pad steps move no byte.
//   A one-word input buffer lets the next pixel be taken while the current
//   one drains; a stalled receiver holds the output word and, once the
//   buffer is full, req_tready drops.
//   Reset (synchronous) empties buffer and output, clears the frame state,
//   sets the CRC to all ones and loads the register reset values.
`default_nettype none

module led_frame_packer_crc (
   input  wire logic        clock,
   input  wire logic        reset,
   // pixel input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   input  wire logic        req_tlast,   // frame_end
   // byte output
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] data_byte
   output logic             rsp_tlast,   // last
   // register writes
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [7:0]  csr_wdata
);
   import lfp_pkg::*;

   cfg_type   cfg;
   pixel_type buf_ff, buf_in;
   logic      buf_valid_ff, buf_valid_in;
   logic      buf_take;
   logic      req_accept;

   // buffer takes a word only when empty, so ready is a plain register output
   assign req_tready = !buf_valid_ff;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      buf_valid_in = buf_valid_ff;
      buf_in       = buf_ff;
      if (req_accept) begin
         buf_valid_in = 1'b1;
         buf_in       = '{red:       req_tdata[7:0],
                          green:     req_tdata[15:8],
                          blue:      req_tdata[23:16],
                          frame_end: req_tlast};
      end else if (buf_take) begin
         buf_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   lfp_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lfp_emitter u_emit (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pix_valid  (buf_valid_ff),
      .pix        (buf_ff),
      .pix_take   (buf_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/lfp_cfg_regs.sv =====
// Configuration register file of the LED frame packer.
// Uses lfp_pkg for the register indexes and the cfg_type struct.
`default_nettype none

module lfp_cfg_regs (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_we,
   input  wire logic [1:0]      csr_addr,
   input  wire logic [7:0]      csr_wdata,
   output lfp_pkg::cfg_type     cfg
);
   import lfp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_COLOR_MODE: cfg_in.color_mode       = csr_wdata[0];
            CSR_SMOOTHING:  cfg_in.smoothing_level  = csr_wdata;
            CSR_USE_CRC:    cfg_in.use_crc          = csr_wdata[0];
            CSR_FW_VERSION: cfg_in.firmware_version = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.color_mode       <= 1'b0;
         cfg_ff.smoothing_level  <= 8'd0;
         cfg_ff.use_crc          <= 1'b1;
         cfg_ff.firmware_version <= 8'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lfp_emitter.sv =====
// Byte sequencer of the LED frame packer: header, pixel bytes, CRC padding,
// trailer and close byte, with the CRC register and the output word register.
// Uses lfp_pkg for types, constants, pack_pixel and crc_feed.
`default_nettype none

module lfp_emitter (
   input  wire logic              clock,
   input  wire logic              reset,
   input  lfp_pkg::cfg_type       cfg,
   input  wire logic              pix_valid,
   input  lfp_pkg::pixel_type     pix,
   output logic                   pix_take,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast
);
   import lfp_pkg::*;

   emit_state_type state_ff, state_in;
   logic [1:0]  idx_ff, idx_in;
   logic [31:0] crc_ff, crc_in;
   logic [1:0]  phase_ff, phase_in;
   logic        in_frame_ff, in_frame_in;

   packed_pix_type item_ff, item_in;
   logic        fend_ff, fend_in;
   logic [7:0]  mask_ff, mask_in;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_data_ff, out_data_in;
   logic        out_last_ff, out_last_in;

   logic        out_free;
   logic        emit;
   logic [7:0]  emit_byte;
   logic        emit_last;
   logic        done;
   logic        load;
   logic [7:0]  cur_pix;
   logic [7:0]  conf_byte;
   logic [7:0]  cmd_byte;
   logic [31:0] trail_word;
   logic [1:0]  phase_nx;
   logic        smooth_ok;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign smooth_ok = cfg.smoothing_level <= SMOOTH_MAX;
   assign cmd_byte  = smooth_ok ? CMD_SMOOTH : CMD_PLAIN;
   assign conf_byte = {cfg.use_crc, (smooth_ok ? cfg.smoothing_level[6:0] : 7'd0)};
   assign trail_word = cfg.use_crc ? crc_ff : 32'd0;
   assign phase_nx  = phase_ff + 2'd1;

   always_comb begin
      unique case (idx_ff)
         2'd0:    cur_pix = item_ff.b0;
         2'd1:    cur_pix = item_ff.b1;
         default: cur_pix = item_ff.b2;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      crc_in      = crc_ff;
      phase_in    = phase_ff;
      in_frame_in = in_frame_ff;
      emit        = 1'b0;
      emit_byte   = 8'h00;
      emit_last   = 1'b0;
      done        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_HEAD: begin
            if (out_free) begin
               emit = 1'b1;
               unique case (idx_ff)
                  2'd0: emit_byte = BYTE_SYNC0;
                  2'd1: emit_byte = BYTE_SYNC1;
                  2'd2: emit_byte = cmd_byte;
                  2'd3: emit_byte = conf_byte;
               endcase
               if (idx_ff == 2'd3) begin
                  state_in    = ST_PIX;
                  idx_in      = 2'd0;
                  in_frame_in = 1'b1;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         ST_PIX: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = cur_pix;
               crc_in    = crc_feed(crc_ff, cur_pix & mask_ff);
               phase_in  = phase_nx;
               if (idx_ff == item_ff.last_idx) begin
                  idx_in = 2'd0;
                  if (!fend_ff) begin
                     done = 1'b1;
                  end else if (cfg.firmware_version > FW_CRC_MIN) begin
                     // zero padding only matters when the CRC goes out
                     state_in = (cfg.use_crc && phase_nx != 2'd0) ? ST_PAD : ST_TRAIL;
                  end else begin
                     state_in = ST_CLOSE;
                  end
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         ST_PAD: begin
            crc_in   = crc_feed(crc_ff, 8'h00);
            phase_in = phase_nx;
            if (phase_nx == 2'd0) begin
               state_in = ST_TRAIL;
            end
         end
         ST_TRAIL: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = esc_sub(trail_word[{idx_ff, 3'b000} +: 8]);
               if (idx_ff == 2'd3) begin
                  state_in = ST_CLOSE;
               end
               idx_in = idx_ff + 2'd1;
            end
         end
         ST_CLOSE: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_byte   = BYTE_ESC;
               emit_last   = 1'b1;
               crc_in      = CRC_INIT;
               phase_in    = 2'd0;
               in_frame_in = 1'b0;
               done        = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         state_in = ST_IDLE;
      end

      // next pixel enters as the current one hands over its last word
      load = pix_valid && (state_ff == ST_IDLE || done);
      if (load) begin
         state_in = in_frame_in ? ST_PIX : ST_HEAD;
         idx_in   = 2'd0;
      end
   end

   assign pix_take = load;
   assign item_in  = load ? pack_pixel(cfg.color_mode, pix) : item_ff;
   assign fend_in  = load ? pix.frame_end : fend_ff;
   assign mask_in  = load ? (cfg.color_mode ? MASK_555 : MASK_888) : mask_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_data_in  = emit_byte;
         out_last_in  = emit_last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= 2'd0;
         crc_ff       <= CRC_INIT;
         phase_ff     <= 2'd0;
         in_frame_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         phase_ff     <= phase_in;
         in_frame_ff  <= in_frame_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      fend_ff     <= fend_in;
      mask_ff     <= mask_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lfp_checker.sv =====
// Port-level checks for the LED frame packer, bound to the top level.
// Uses lfp_pkg for frame constants.
`default_nettype none

module lfp_port_assert (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);
   import lfp_pkg::*;

   logic frame_open_ff;   // low between a close word and the next header

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         frame_open_ff <= !rsp_tlast;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output word present right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled output word changed");

   a_close_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == BYTE_ESC)
      else $error("frame closed with a byte other than F5");

   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !frame_open_ff |-> rsp_tdata == BYTE_SYNC0 && !rsp_tlast)
      else $error("frame does not open with the sync byte");

   // one-word input buffer: a taken word fills it, so ready is low in the next cycle
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready stayed high after a word was taken");

endmodule

bind led_frame_packer_crc lfp_port_assert u_lfp_port_assert (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== dv/lfp_checker.sv =====
`timescale 1ns / 100ps
// Frame byte checker for the LED frame packer: follows register writes and accepted
// pixels, works out the frame bytes and compares them with each output word.
// Depends on lfp_pkg.
module lfp_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [23:0] req_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   input  wire logic        req_tlast,   // frame_end
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,   // [7:0] data_byte
   input  wire logic        rsp_tlast,   // last
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [7:0]  csr_wdata,
   output int               fail_count,
   output int               bytes_pending
);
   import lfp_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   frame_byte_type frame_bytes_q[$];

   // shadow registers
   logic        color_mode;
   logic [7:0]  smoothing;
   logic        use_crc;
   logic [7:0]  fw_version;

   // frame state
   logic [31:0] crc_acc;
   logic        in_frame;
   logic [1:0]  byte_phase;

   initial fail_count = 0;

   // CRC-32, MSB first, one byte
   function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] d);
      logic [31:0] x;
      x = c ^ {d, 24'h00_0000};
      repeat (8) begin
         if (x[31]) x = {x[30:0], 1'b0} ^ CRC_POLY;
         else       x = {x[30:0], 1'b0};
      end
      return x;
   endfunction

   function automatic logic [7:0] no_esc(input logic [7:0] b);
      return (b == BYTE_ESC) ? BYTE_ESC_SUB : b;
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic last);
      frame_byte_type fb;
      fb.data = b;
      fb.last = last;
      frame_bytes_q.push_back(fb);
   endtask

   task automatic push_pixel_byte(input logic [7:0] b);
      push_byte(b, 1'b0);
      crc_acc    = crc32_byte(crc_acc, b & (color_mode ? MASK_555 : MASK_888));
      byte_phase = byte_phase + 2'd1;
   endtask

   task automatic frame_bytes_for(input logic [23:0] rgb, input logic frame_end);
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  conf;
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [31:0] trailer;
      red   = rgb[7:0];
      green = rgb[15:8];
      blue  = rgb[23:16];
      if (!in_frame) begin
         conf    = (smoothing <= SMOOTH_MAX) ? {1'b0, smoothing[6:0]} : 8'h00;
         conf[7] = use_crc;
         push_byte(BYTE_SYNC0, 1'b0);
         push_byte(BYTE_SYNC1, 1'b0);
         push_byte((smoothing <= SMOOTH_MAX) ? CMD_SMOOTH : CMD_PLAIN, 1'b0);
         push_byte(conf, 1'b0);
         crc_acc    = CRC_INIT;
         byte_phase = 2'd0;
         in_frame   = 1'b1;
      end
      if (!color_mode) begin
         push_pixel_byte(no_esc(green));
         push_pixel_byte(no_esc(red));
         push_pixel_byte(no_esc(blue));
      end else begin
         lo = {green[4:3], 1'b0, red[7:3]};
         hi = {blue[7:3], green[7:5]};
         if (lo == BYTE_ESC) lo = lo ^ ESC_FLIP_B1;
         if (hi == BYTE_ESC) hi = hi ^ ESC_FLIP_B2;
         push_pixel_byte(lo);
         push_pixel_byte(hi);
      end
      if (frame_end) begin
         // pad the CRC over zero bytes to a whole number of 32-bit words
         while (byte_phase != 2'd0) begin
            crc_acc    = crc32_byte(crc_acc, 8'h00);
            byte_phase = byte_phase + 2'd1;
         end
         if (fw_version > FW_CRC_MIN) begin
            trailer = use_crc ? crc_acc : 32'h0;
            for (int i = 0; i < 4; i++) push_byte(no_esc(trailer[8*i +: 8]), 1'b0);
         end
         push_byte(BYTE_ESC, 1'b1);
         crc_acc    = CRC_INIT;
         byte_phase = 2'd0;
         in_frame   = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      frame_byte_type want;
      if (reset) begin
         color_mode = 1'b0;
         smoothing  = 8'd0;
         use_crc    = 1'b1;
         fw_version = 8'd5;
         crc_acc    = CRC_INIT;
         in_frame   = 1'b0;
         byte_phase = 2'd0;
         frame_bytes_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_COLOR_MODE: color_mode = csr_wdata[0];
               CSR_SMOOTHING:  smoothing  = csr_wdata;
               CSR_USE_CRC:    use_crc    = csr_wdata[0];
               CSR_FW_VERSION: fw_version = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) frame_bytes_for(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (frame_bytes_q.size() == 0) begin
               $display("%0t: unexpected word, actual data %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               want = frame_bytes_q.pop_front();
               if (rsp_tdata !== want.data) begin
                  $display("%0t: data_byte mismatch, expected %h actual %h",
                           $time, want.data, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last mismatch, expected %b actual %b",
                           $time, want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
      bytes_pending <= frame_bytes_q.size();
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the LED frame packer testbench: clock, reset, pixel and register stimulus,
// receiver stalls, watchdog and verdict. Uses lfp_pkg, lfp_checker and the packer.
module tb_top;
   import lfp_pkg::*;

   localparam int IDLE_LIMIT   = 2000;  // cycles with no word moved
   localparam int SETTLE_TICKS = 16;    // covers pad, trailer and close of the sequencer
   localparam int RAND_PIXELS  = 230;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // [7:0] red, [15:8] green, [23:16] blue
   logic        req_tlast;   // frame_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] data_byte
   logic        rsp_tlast;   // last
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [7:0]  csr_wdata;

   int fail_count;
   int bytes_pending;
   int send_idle_pct;
   int stall_pct;
   int pixels_sent;
   int idle_cycles;

   led_frame_packer_crc dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   lfp_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .bytes_pending (bytes_pending)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // receiver: random back-pressure, one decision per cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // watchdog: ends the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // one pixel word, with random gaps ahead of it; returns once it is taken
   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic frame_end);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {blue, green, red};
      req_tlast  <= frame_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
   endtask

   // hold off until every expected byte is out and the sequencer has gone quiet
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(input logic mode, input logic [7:0] smooth,
                            input logic crc_on, input logic [7:0] fw);
      write_reg(CSR_COLOR_MODE, {7'd0, mode});
      write_reg(CSR_SMOOTHING, smooth);
      write_reg(CSR_USE_CRC, {7'd0, crc_on});
      write_reg(CSR_FW_VERSION, fw);
   endtask

   // channel values leaning towards the escape code and the extremes
   function automatic logic [7:0] pick_channel();
      case ($urandom_range(0, 9))
         0: return BYTE_ESC;
         1: return 8'h00;
         2: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_smoothing();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return SMOOTH_MAX;
         2: return SMOOTH_MAX + 8'd1;
         3: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_fw();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return FW_CRC_MIN;
         2: return FW_CRC_MIN + 8'd1;
         3: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_frame(input int n_pix);
      for (int i = 0; i < n_pix; i++)
         send_pixel(pick_channel(), pick_channel(), pick_channel(), i == n_pix - 1);
   endtask

   initial begin
      logic [31:0] crc;
      logic [7:0]  esc_red;
      logic [7:0]  esc_green;
      logic        found;
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= 24'h0;
      req_tlast     <= 1'b0;
      csr_we        <= 1'b0;
      csr_addr      <= CSR_COLOR_MODE;
      csr_wdata     <= 8'h00;
      send_idle_pct = 25;
      stall_pct     = 60;
      pixels_sent   = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part, reset settings first (GRB888, CRC on, fw 5) ----
      // single-pixel frame with escape on blue: header, pixel, pad 1, trailer, close
      send_pixel(8'hFF, 8'h00, BYTE_ESC, 1'b1);
      // three pixels: 9 bytes so three pad bytes; all-escape pixel in the middle
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(BYTE_ESC, BYTE_ESC, BYTE_ESC, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

      // trailer escape: find a one-pixel GRB888 frame whose CRC holds an F5 byte
      found     = 1'b0;
      esc_red   = 8'h03;
      esc_green = 8'h03;
      for (int g = 0; g < 16 && !found; g++) begin
         for (int r = 0; r < 16 && !found; r++) begin
            crc = chk.crc32_byte(CRC_INIT, {g[3:0], 4'h0});
            crc = chk.crc32_byte(crc, {r[3:0], 4'h0});
            crc = chk.crc32_byte(crc, 8'h30);
            crc = chk.crc32_byte(crc, 8'h00);
            if (crc[7:0] == BYTE_ESC || crc[15:8] == BYTE_ESC ||
                crc[23:16] == BYTE_ESC || crc[31:24] == BYTE_ESC) begin
               found     = 1'b1;
               esc_red   = {r[3:0], 4'h3};
               esc_green = {g[3:0], 4'h3};
            end
         end
      end
      send_pixel(esc_red, esc_green, 8'h33, 1'b1);

      // RGB555, smoothing at its upper bound, top firmware version
      wait_idle();
      write_all(1'b1, SMOOTH_MAX, 1'b1, 8'd255);
      send_pixel(8'h5A, 8'hA8, 8'hF0, 1'b1);   // second byte hits the escape code
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);   // four bytes, no pad
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

      // smoothing just over the bound: plain command, zero trailer
      wait_idle();
      write_all(1'b0, SMOOTH_MAX + 8'd1, 1'b0, FW_CRC_MIN + 8'd1);
      send_pixel(8'h12, 8'h34, 8'h56, 1'b1);

      // firmware at the threshold: no trailer, close follows the pixels
      wait_idle();
      write_all(1'b0, 8'd255, 1'b1, FW_CRC_MIN);
      send_pixel(8'hA5, 8'h5A, 8'hC3, 1'b0);
      send_pixel(8'h3C, 8'h96, 8'h69, 1'b1);

      wait_idle();
      write_all(1'b1, 8'd0, 1'b0, 8'd0);
      send_pixel(8'h81, 8'h7E, 8'h18, 1'b1);

      // settings moved mid-frame: header keeps the first ones, packing follows
      // the mode of each pixel, the trailer takes what stands at the last one
      wait_idle();
      write_all(1'b0, 8'd7, 1'b1, 8'd5);
      send_pixel(8'h11, 8'h22, 8'h33, 1'b0);
      wait_idle();
      write_reg(CSR_COLOR_MODE, 8'h01);
      write_reg(CSR_SMOOTHING, 8'd200);
      write_reg(CSR_USE_CRC, 8'h00);
      send_pixel(8'h44, 8'h55, 8'h66, 1'b0);
      wait_idle();
      write_reg(CSR_USE_CRC, 8'h01);
      write_reg(CSR_FW_VERSION, 8'd200);
      send_pixel(8'h77, 8'h88, 8'h99, 1'b1);

      // ---- random frames in three idling phases ----
      pixels_sent = 0;
      while (pixels_sent < RAND_PIXELS) begin
         if (pixels_sent >= 2 * RAND_PIXELS / 3) begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end else if (pixels_sent >= RAND_PIXELS / 3) begin
            send_idle_pct = 60;
            stall_pct     = 25;
         end
         if ($urandom_range(0, 3) == 0) begin
            wait_idle();
            write_all(1'($urandom_range(0, 1)), pick_smoothing(),
                      1'($urandom_range(0, 1)), pick_fw());
         end
         send_frame($urandom_range(1, 8));
      end

      wait_idle();
      if (fail_count == 0 && bytes_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/lfp_pkg.sv
hw/rtl/lfp_cfg_regs.sv
hw/rtl/lfp_emitter.sv
hw/rtl/led_frame_packer_crc.sv
hw/rtl/lfp_checker.sv
dv/lfp_checker.sv
dv/tb_top.sv
